### design/ssrs_pkg.sv
package ssrs_pkg;

  // Default sizes of the store.
  localparam int DefRows      = 1024;
  localparam int DefRowSlots  = 8;
  localparam int DefValueBits = 64;

  // Fixed field widths of the words on the ports.
  localparam int ROW_IDX_W    = 10;
  localparam int COL_W        = 10;
  localparam int PORT_VALUE_W = 64;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 14;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OVERWRITE = 3'd0,
    STATUS_INSERT    = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_HIT       = 3'd3,
    STATUS_MISS      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  // Handshake from the column scan unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

### design/ssrs_ram.sv
module ssrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ssrs_scan.sv
module ssrs_scan #(
  parameter int ROW_SLOTS = ssrs_pkg::DefRowSlots,
  parameter int POS_W     = $clog2(ROW_SLOTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ssrs_pkg::COL_W-1:0] key_i,
  input  logic [POS_W-1:0]        len_i,
  input  logic [ssrs_pkg::COL_W-1:0] cols_i [ROW_SLOTS],
  output ssrs_pkg::scan_stat_t    stat_o,
  output logic [POS_W-1:0]        pos_o
);
  import ssrs_pkg::*;

  localparam int SLOT_AW = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;

  logic             busy_q, busy_d;
  logic [POS_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0] cur;
  logic             in_row;
  logic             stop;

  // One comparator walks the row one slot per cycle until it reaches the
  // first slot whose column is not below the key, or the end of the row.
  assign in_row = idx_q < len_i;
  assign cur    = cols_i[idx_q[SLOT_AW-1:0]];
  assign stop   = !in_row || (cur >= key_i);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      if (stop) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign stat_o.done  = busy_q && stop;
  assign stat_o.found = in_row && (cur == key_i);
  assign pos_o        = idx_q;

endmodule

### design/sorted_sparse_row_store.sv
// Sorted sparse row store: a square sparse matrix kept as ROWS rows of up to
// ROW_SLOTS (column, value) entries in ascending column order. Each row, with
// its length, lives in one wide word of a single-port-write RAM. A write to a
// present column overwrites its value, a write to a new column is inserted
// at its sorted place and bumps the element count, and a write to a new
// column of a full row is dropped with the "row full" status. A read returns
// the value with a hit status, or zero with a miss status. After reset the
// block runs a clearing pass that zeroes every row length; its input stall
// stays high until that pass is done. One word is then taken at a time: the
// row is read, one shared comparator scans the slots at one slot per cycle
// up to the sorted place of the column, an updated row is written back when
// the word changes it, and the result is then posted to the output register.
// A word whose row index is not below ROWS skips the row read and scan. A
// finished result waits in the output register while the next word is taken.
module sorted_sparse_row_store #(
  parameter int ROWS       = ssrs_pkg::DefRows,
  parameter int ROW_SLOTS  = ssrs_pkg::DefRowSlots,
  parameter int VALUE_BITS = ssrs_pkg::DefValueBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [ssrs_pkg::ROW_IDX_W-1:0]       row_index_i,
  input  logic [ssrs_pkg::COL_W-1:0]           column_index_i,
  input  logic [ssrs_pkg::PORT_VALUE_W-1:0]    write_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ssrs_pkg::STATUS_W-1:0]        status_o,
  output logic [ssrs_pkg::PORT_VALUE_W-1:0]    read_value_o,
  output logic [ssrs_pkg::COUNT_W-1:0]         element_count_o
);
  import ssrs_pkg::*;

  localparam int ROW_AW  = $clog2(ROWS);
  localparam int POS_W   = $clog2(ROW_SLOTS + 1);
  localparam int SLOT_AW = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int SLOT_W  = COL_W + VALUE_BITS;
  localparam int WORD_W  = POS_W + ROW_SLOTS * SLOT_W;

  // Sequencer state.
  state_e state_q, state_d;
  logic [ROW_AW-1:0] clr_q, clr_d;

  // The word being worked on.
  logic                  func_q;
  logic [ROW_AW-1:0]     row_addr_q;
  logic [COL_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] wval_q;
  logic                  take;

  // Row index in range, and its RAM address at any ROWS.
  logic [ROW_AW+ROW_IDX_W-1:0] row_ext;
  logic [ROW_AW-1:0]           row_addr_in;
  logic                        row_ok;

  assign row_ext     = {{ROW_AW{1'b0}}, row_index_i};
  assign row_addr_in = row_ext[ROW_AW-1:0];
  assign row_ok      = 32'(row_index_i) < ROWS;

  // Working copy of the addressed row.
  logic [POS_W-1:0]      len_q;
  logic [COL_W-1:0]      rcol_q [ROW_SLOTS];
  logic [VALUE_BITS-1:0] rval_q [ROW_SLOTS];
  logic                  row_load;
  logic                  row_ovw;
  logic                  row_ins;

  // Result held until the output register is free.
  status_e               res_status_q, res_status_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic [COUNT_W-1:0]    total_q, total_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q;
  logic [PORT_VALUE_W-1:0] out_value_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic                    out_load;

  // RAM.
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] row_word;

  // Scan unit.
  logic             scan_start;
  scan_stat_t       scan_stat;
  logic [POS_W-1:0] scan_pos;

  ssrs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (row_addr_in),
    .rdata_o (ram_rdata)
  );

  ssrs_scan #(
    .ROW_SLOTS (ROW_SLOTS),
    .POS_W     (POS_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   (key_q),
    .len_i   (len_q),
    .cols_i  (rcol_q),
    .stat_o  (scan_stat),
    .pos_o   (scan_pos)
  );

  // Row word layout: the length in the low bits, then each slot as its
  // column followed by its value.
  assign row_word[POS_W-1:0] = len_q;

  for (genvar k = 0; k < ROW_SLOTS; k++) begin : g_slot
    localparam int Base = POS_W + k * SLOT_W;

    assign row_word[Base +: COL_W]              = rcol_q[k];
    assign row_word[Base + COL_W +: VALUE_BITS] = rval_q[k];

    // Each slot either loads from the RAM, takes the new value, or on an
    // insert takes the entry from the slot below it when it lies above
    // the sorted place.
    always_ff @(posedge clk_i) begin
      if (row_load) begin
        rcol_q[k] <= ram_rdata[Base +: COL_W];
        rval_q[k] <= ram_rdata[Base + COL_W +: VALUE_BITS];
      end else if ((row_ovw || row_ins) && (scan_pos == POS_W'(k))) begin
        rcol_q[k] <= key_q;
        rval_q[k] <= wval_q;
      end else if (row_ins && (scan_pos < POS_W'(k)) && (POS_W'(k) <= len_q)) begin
        if (k > 0) begin
          rcol_q[k] <= rcol_q[(k > 0) ? k - 1 : 0];
          rval_q[k] <= rval_q[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_load) begin
      len_q <= ram_rdata[POS_W-1:0];
    end else if (row_ins) begin
      len_q <= len_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q     <= func_i;
      row_addr_q <= row_addr_in;
      key_q      <= column_index_i;
      wval_q     <= write_value_i[VALUE_BITS-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    take         = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = row_addr_q;
    ram_wdata    = row_word;
    row_load     = 1'b0;
    row_ovw      = 1'b0;
    row_ins      = 1'b0;
    scan_start   = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    total_d      = total_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      S_CLEAR: begin
        // Zero every row length, one row per cycle.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ROW_AW'(1);
        if (clr_q == ROW_AW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          take = 1'b1;
          if (row_ok) begin
            state_d = S_READ;
          end else begin
            // A row beyond the matrix behaves as a full, empty row.
            res_status_d = (func_i == FUNC_READ) ? STATUS_MISS : STATUS_FULL;
            res_value_d  = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_READ: begin
        row_load   = 1'b1;
        scan_start = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          res_value_d = '0;
          if (func_q == FUNC_READ) begin
            if (scan_stat.found) begin
              res_status_d = STATUS_HIT;
              res_value_d  = rval_q[scan_pos[SLOT_AW-1:0]];
            end else begin
              res_status_d = STATUS_MISS;
            end
            state_d = S_DONE;
          end else if (scan_stat.found) begin
            row_ovw      = 1'b1;
            res_status_d = STATUS_OVERWRITE;
            state_d      = S_WRITE;
          end else if (len_q >= POS_W'(ROW_SLOTS)) begin
            res_status_d = STATUS_FULL;
            state_d      = S_DONE;
          end else begin
            row_ins      = 1'b1;
            total_d      = total_q + COUNT_W'(1);
            res_status_d = STATUS_INSERT;
            state_d      = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ram_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= PORT_VALUE_W'(res_value_q);
      out_count_q  <= total_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign read_value_o    = out_value_q;
  assign element_count_o = out_count_q;

endmodule
